FILE: src/bgal_pkg.sv
// Shared types, constants, threshold table and microcode encodings for the battery gauge.
package bgal_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_W     = 18;
    localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int KCNT_W       = 5;
    localparam int TABLE_LEN    = 21;

    localparam logic [15:0] BAD_SAMPLE   = 16'hFFFF;
    localparam logic [1:0]  STATUS_FULL  = 2'd2;
    localparam logic [6:0]  PERCENT_FULL = 7'd100;
    localparam logic [3:0]  LEVEL_MAX    = 4'd9;

    localparam int OP_W   = 3;
    localparam int COND_W = 3;
    localparam int PC_W   = 3;

    localparam logic [OP_W-1:0] OP_ACCEPT = 3'd0;
    localparam logic [OP_W-1:0] OP_ISSUE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ACCUM  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd3;
    localparam logic [OP_W-1:0] OP_SAT    = 3'd4;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd7;

    localparam logic [COND_W-1:0] C_NEVER  = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
    localparam logic [COND_W-1:0] C_NOGOOD = 3'd2;
    localparam logic [COND_W-1:0] C_SUM    = 3'd3;
    localparam logic [COND_W-1:0] C_DIV    = 3'd4;
    localparam logic [COND_W-1:0] C_SCAN   = 3'd5;
    localparam logic [COND_W-1:0] C_EMIT   = 3'd6;

    typedef struct packed {
        logic [15:0] adc_sample;
        logic [1:0]  chg_state;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] avg_voltage;
        logic [6:0]  percent;
        logic [3:0]  level;
    } out_beat_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctrl_t;

    typedef struct packed {
        logic no_good;
        logic sum_more;
        logic div_more;
        logic scan_more;
        logic emit_wait;
    } status_t;

    function automatic logic [15:0] thresh_mv(input logic [KCNT_W-1:0] idx);
        logic [15:0] t;
        case (idx)
            5'd0:    t = 16'd3200;
            5'd1:    t = 16'd3350;
            5'd2:    t = 16'd3450;
            5'd3:    t = 16'd3520;
            5'd4:    t = 16'd3580;
            5'd5:    t = 16'd3620;
            5'd6:    t = 16'd3650;
            5'd7:    t = 16'd3680;
            5'd8:    t = 16'd3710;
            5'd9:    t = 16'd3740;
            5'd10:   t = 16'd3770;
            5'd11:   t = 16'd3800;
            5'd12:   t = 16'd3830;
            5'd13:   t = 16'd3860;
            5'd14:   t = 16'd3900;
            5'd15:   t = 16'd3940;
            5'd16:   t = 16'd3980;
            5'd17:   t = 16'd4020;
            5'd18:   t = 16'd4060;
            5'd19:   t = 16'd4100;
            5'd20:   t = 16'd4200;
            default: t = 16'd0;
        endcase
        return t;
    endfunction

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            3'd0:    w = '{op: OP_ACCEPT, cond: C_NOGOOD, target: 3'd0};
            3'd1:    w = '{op: OP_ISSUE,  cond: C_NEVER,  target: 3'd0};
            3'd2:    w = '{op: OP_ACCUM,  cond: C_SUM,    target: 3'd2};
            3'd3:    w = '{op: OP_DIV,    cond: C_DIV,    target: 3'd3};
            3'd4:    w = '{op: OP_SAT,    cond: C_NEVER,  target: 3'd0};
            3'd5:    w = '{op: OP_SCAN,   cond: C_SCAN,   target: 3'd5};
            3'd6:    w = '{op: OP_EMIT,   cond: C_EMIT,   target: 3'd6};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS, target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

FILE: src/bgal_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module bgal_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  bgal_pkg::status_t status,
    output bgal_pkg::ctrl_t   ctrl
);

    logic [bgal_pkg::PC_W-1:0] pc_reg;
    logic [bgal_pkg::PC_W-1:0] pc_next;
    bgal_pkg::uword_t          uw;
    logic                      take;

    assign uw      = bgal_pkg::ucode(pc_reg);
    assign ctrl.op = uw.op;

    always_comb begin
        unique case (uw.cond)
            bgal_pkg::C_NEVER:  take = 1'b0;
            bgal_pkg::C_ALWAYS: take = 1'b1;
            bgal_pkg::C_NOGOOD: take = status.no_good;
            bgal_pkg::C_SUM:    take = status.sum_more;
            bgal_pkg::C_DIV:    take = status.div_more;
            bgal_pkg::C_SCAN:   take = status.scan_more;
            bgal_pkg::C_EMIT:   take = status.emit_wait;
            default:            take = 1'b0;
        endcase
        pc_next = take ? uw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: src/bgal_datapath.sv
// Datapath: sample window memory, accumulator, serial divider, table scan and result register.
module bgal_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  bgal_pkg::ctrl_t     ctrl,
    output bgal_pkg::status_t   status,
    input  logic                s_valid,
    output logic                s_ready,
    input  bgal_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bgal_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data
);

    localparam int PTR_W  = bgal_pkg::PTR_W;
    localparam int CNT_W  = bgal_pkg::CNT_W;
    localparam int SUM_W  = bgal_pkg::SUM_W;
    localparam int KCNT_W = bgal_pkg::KCNT_W;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(bgal_pkg::WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FILL_MAX = CNT_W'(bgal_pkg::WINDOW_DEPTH);
    localparam logic [KCNT_W-1:0] DIV_LAST = KCNT_W'(SUM_W - 1);
    localparam logic [KCNT_W-1:0] TAB_END  = KCNT_W'(bgal_pkg::TABLE_LEN);

    logic [bgal_pkg::SAMPLE_W-1:0] win_mem [bgal_pkg::WINDOW_DEPTH];
    logic [bgal_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [KCNT_W-1:0] kcnt_reg, kcnt_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [15:0]       avg_reg, avg_next;
    logic              full_reg, full_next;
    logic [6:0]        last_reg, last_next;
    logic              m_valid_reg, m_valid_next;
    bgal_pkg::out_beat_t m_data_reg, m_data_next;

    logic              accept;
    logic              good;
    logic [CNT_W:0]    trial;
    logic              ge;
    logic              hit;
    logic [6:0]        pct;
    logic [3:0]        lvl;
    logic              differs;

    assign s_ready = (ctrl.op == bgal_pkg::OP_ACCEPT);
    assign accept  = s_valid && s_ready;
    assign good    = accept && (s_data.adc_sample != bgal_pkg::BAD_SAMPLE);

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign ge    = (trial >= {1'b0, fill_reg});
    assign hit   = (kcnt_reg == TAB_END) || (avg_reg < bgal_pkg::thresh_mv(kcnt_reg));

    always_comb begin
        if (full_reg || (kcnt_reg == TAB_END)) begin
            pct = bgal_pkg::PERCENT_FULL;
        end else begin
            pct = 7'({kcnt_reg, 2'b00}) + 7'(kcnt_reg);
        end
        if (full_reg || (kcnt_reg[KCNT_W-1:1] > 4'(bgal_pkg::LEVEL_MAX))) begin
            lvl = bgal_pkg::LEVEL_MAX;
        end else begin
            lvl = 4'(kcnt_reg[KCNT_W-1:1]);
        end
    end

    assign differs = (pct != last_reg);

    assign status.no_good   = !good;
    assign status.sum_more  = (cnt_reg < fill_reg);
    assign status.div_more  = (kcnt_reg != DIV_LAST);
    assign status.scan_more = !hit;
    assign status.emit_wait = differs && m_valid_reg && !m_ready;

    always_comb begin
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        kcnt_next    = kcnt_reg;
        acc_next     = acc_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        avg_next     = avg_reg;
        full_next    = full_reg;
        last_next    = last_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (ctrl.op)
            bgal_pkg::OP_ACCEPT: begin
                if (good) begin
                    wp_next   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    fill_next = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
                    full_next = (s_data.chg_state == bgal_pkg::STATUS_FULL);
                    acc_next  = '0;
                    cnt_next  = '0;
                end
            end
            bgal_pkg::OP_ISSUE: begin
                cnt_next = cnt_reg + 1'b1;
            end
            bgal_pkg::OP_ACCUM: begin
                acc_next = acc_reg + SUM_W'(rd_data_reg);
                if (cnt_reg < fill_reg) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    quo_next  = acc_reg + SUM_W'(rd_data_reg);
                    rem_next  = '0;
                    kcnt_next = '0;
                end
            end
            bgal_pkg::OP_DIV: begin
                rem_next  = ge ? CNT_W'(trial - {1'b0, fill_reg}) : trial[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], ge};
                kcnt_next = (kcnt_reg == DIV_LAST) ? '0 : kcnt_reg + 1'b1;
            end
            bgal_pkg::OP_SAT: begin
                avg_next = (|quo_reg[SUM_W-1:16]) ? 16'hFFFF : quo_reg[15:0];
            end
            bgal_pkg::OP_SCAN: begin
                if (!hit) begin
                    kcnt_next = kcnt_reg + 1'b1;
                end
            end
            bgal_pkg::OP_EMIT: begin
                if (differs && !(m_valid_reg && !m_ready)) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{avg_voltage: avg_reg, percent: pct, level: lvl};
                    last_next    = pct;
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr_en) begin
            wp_next   = '0;
            fill_next = '0;
            last_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (good) begin
            win_mem[wp_reg] <= {s_data.adc_sample, 2'b00};
        end
        rd_data_reg <= win_mem[cnt_reg[PTR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        kcnt_reg   <= kcnt_next;
        acc_reg    <= acc_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        avg_reg    <= avg_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/battery_gauge_average_lookup.sv
// Top level of the battery gauge: window average of ADC samples mapped to a charge percent.
//
// One sample is taken at a time. A bad-conversion sample is dropped in its accept cycle and
// the block stays ready. A good sample runs through a microcoded program: store it, start the
// window read, sum each filled window entry (up to 8), divide the sum one bit at a time over
// its 21 bits in the serial divider, saturate, scan the thresholds until the first one above
// the average (or the table end), emit and return to the accept step; the block takes no new
// sample until the program is through. A result is held in an output register and is emitted
// only when the percent changes; the emit step waits only if the previous result has not been
// taken. Writing initial_percent empties the window and sets the last reported percent.
module battery_gauge_average_lookup (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bgal_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bgal_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data
);

    bgal_pkg::ctrl_t   ctrl;
    bgal_pkg::status_t status;

    bgal_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    bgal_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .status      (status),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

FILE: src/bgal_checker.sv
// Port-level checker for the battery gauge, bound to the top level.
module bgal_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input bgal_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input bgal_pkg::out_beat_t m_data
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_busy_after_good: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.adc_sample != bgal_pkg::BAD_SAMPLE) |=> !s_ready)
        else $error("ready after a good sample beat");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.percent <= bgal_pkg::PERCENT_FULL)
                 && (m_data.level <= bgal_pkg::LEVEL_MAX)
                 && ((m_data.percent != bgal_pkg::PERCENT_FULL)
                     || (m_data.level == bgal_pkg::LEVEL_MAX)))
        else $error("result percent or level out of range");

endmodule

bind battery_gauge_average_lookup bgal_checker u_bgal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the battery gauge: averaged ADC samples mapped to charge percent.
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 150;
    localparam int PCT_STEP      = 5;
    localparam int LEVEL_DIV     = 10;
    localparam int AVG_MAX       = 65535;
    localparam int MAX_GOOD      = 65534;
    localparam int PTR_W         = bgal_pkg::PTR_W;

    localparam logic [1:0] ST_DISCHARGE = 2'd0;
    localparam logic [1:0] ST_CHARGE    = 2'd1;
    localparam logic [1:0] ST_UNUSED    = 2'd3;

    // entry k sits at bits [16*k +: 16]
    localparam logic [16*bgal_pkg::TABLE_LEN-1:0] VOLT_STEPS = {
        16'd4200, 16'd4100, 16'd4060, 16'd4020, 16'd3980, 16'd3940, 16'd3900,
        16'd3860, 16'd3830, 16'd3800, 16'd3770, 16'd3740, 16'd3710, 16'd3680,
        16'd3650, 16'd3620, 16'd3580, 16'd3520, 16'd3450, 16'd3350, 16'd3200
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    bgal_pkg::in_beat_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    bgal_pkg::out_beat_t m_data;
    logic                cfg_wr_en   = 1'b0;
    logic [6:0]          cfg_wr_data = 7'd0;

    bgal_pkg::in_beat_t  sample_q[$];
    bgal_pkg::out_beat_t pending_reports[$];

    logic [17:0] gauge_win [bgal_pkg::WINDOW_DEPTH];
    int          gauge_wr_ptr = 0;
    int          gauge_fill   = 0;
    logic [6:0]  gauge_last_pct = 7'd0;

    int gap_pct    = 0;
    int stall_pct  = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int drift_mv   = 900;

    int n_errors   = 0;
    int n_samples  = 0;
    int n_bad      = 0;
    int n_checked  = 0;
    int n_settings = 0;
    int cycle_count = 0;

    battery_gauge_average_lookup dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("battery_gauge_average_lookup: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic predict_gauge_report(input bgal_pkg::in_beat_t b);
        logic [31:0]         sum;
        logic [31:0]         avg;
        logic [6:0]          pct;
        logic [6:0]          lvl;
        bgal_pkg::out_beat_t r;
        int                  k;
        n_samples++;
        if (b.adc_sample == bgal_pkg::BAD_SAMPLE) begin
            n_bad++;
        end else begin
            gauge_win[PTR_W'(gauge_wr_ptr)] = {b.adc_sample, 2'b00};
            gauge_wr_ptr = (gauge_wr_ptr + 1) % bgal_pkg::WINDOW_DEPTH;
            if (gauge_fill < bgal_pkg::WINDOW_DEPTH)
                gauge_fill++;
            sum = 0;
            for (k = 0; k < gauge_fill; k++)
                sum += gauge_win[PTR_W'(k)];
            avg = sum / gauge_fill;
            if (avg > AVG_MAX)
                avg = AVG_MAX;
            pct = bgal_pkg::PERCENT_FULL;
            for (k = bgal_pkg::TABLE_LEN - 1; k >= 0; k--) begin
                if (avg < VOLT_STEPS[16*k +: 16])
                    pct = 7'(k * PCT_STEP);
            end
            if (b.chg_state == bgal_pkg::STATUS_FULL)
                pct = bgal_pkg::PERCENT_FULL;
            lvl = 7'(pct / LEVEL_DIV);
            if (lvl > bgal_pkg::LEVEL_MAX)
                lvl = 7'(bgal_pkg::LEVEL_MAX);
            if (pct != gauge_last_pct) begin
                r.avg_voltage = avg[15:0];
                r.percent     = pct;
                r.level       = lvl[3:0];
                pending_reports.push_back(r);
                gauge_last_pct = pct;
            end
        end
    endtask

    task automatic check_report(input bgal_pkg::out_beat_t got);
        bgal_pkg::out_beat_t want;
        if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected beat avg=%0d pct=%0d lvl=%0d",
                                      got.avg_voltage, got.percent, got.level));
        end else begin
            want = pending_reports.pop_front();
            n_checked++;
            if (got.avg_voltage !== want.avg_voltage)
                report_mismatch($sformatf("avg_voltage got %0d want %0d",
                                          got.avg_voltage, want.avg_voltage));
            if (got.percent !== want.percent)
                report_mismatch($sformatf("percent got %0d want %0d",
                                          got.percent, want.percent));
            if (got.level !== want.level)
                report_mismatch($sformatf("level got %0d want %0d",
                                          got.level, want.level));
        end
    endtask

    // driver: hold the beat until accepted, then advance or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                predict_gauge_report(s_data);
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (sample_q.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= sample_q.pop_front();
                if ($urandom_range(0, 99) < gap_pct)
                    gap_left <= $urandom_range(1, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready)
                check_report(m_data);
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic bgal_pkg::in_beat_t next_reading();
        bgal_pkg::in_beat_t b;
        int pick;
        pick = $urandom_range(0, 99);
        drift_mv = drift_mv + int'($urandom_range(0, 40)) - 20;
        if (drift_mv < 760)
            drift_mv = 760;
        if (drift_mv > 1080)
            drift_mv = 1080;
        if (pick < 70)
            b.adc_sample = 16'(drift_mv + int'($urandom_range(0, 6)) - 3);
        else if (pick < 80)
            b.adc_sample = bgal_pkg::BAD_SAMPLE;
        else if (pick < 88)
            b.adc_sample = 16'($urandom_range(0, 65535));
        else if (pick < 94)
            b.adc_sample = 16'd0;
        else
            b.adc_sample = 16'(MAX_GOOD);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            b.chg_state = ST_DISCHARGE;
        else if (pick < 70)
            b.chg_state = ST_CHARGE;
        else if (pick < 85)
            b.chg_state = bgal_pkg::STATUS_FULL;
        else
            b.chg_state = ST_UNUSED;
        return b;
    endfunction

    task automatic add_sample(input logic [15:0] mv, input logic [1:0] st);
        bgal_pkg::in_beat_t b;
        b.adc_sample = mv;
        b.chg_state  = st;
        sample_q.push_back(b);
    endtask

    task automatic wait_idle();
        while (sample_q.size() != 0 || s_valid || pending_reports.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input logic [6:0] init_pct, input int gap, input int stall);
        int i;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= init_pct;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gauge_wr_ptr   = 0;
        gauge_fill     = 0;
        gauge_last_pct = init_pct;
        n_settings++;
        @(negedge aclk);
        gap_pct   = gap;
        stall_pct = stall;
        for (i = 0; i < PHASE_ITEMS; i++)
            sample_q.push_back(next_reading());
    endtask

    initial begin
        int i;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        gap_pct   = 30;
        stall_pct = 30;
        add_sample(16'd0, ST_DISCHARGE);
        add_sample(bgal_pkg::BAD_SAMPLE, ST_DISCHARGE);
        add_sample(16'(MAX_GOOD), ST_DISCHARGE);
        add_sample(bgal_pkg::BAD_SAMPLE, bgal_pkg::STATUS_FULL);
        add_sample(16'd800, ST_CHARGE);
        add_sample(16'd799, ST_UNUSED);
        for (i = 0; i < 10; i++)
            add_sample(16'd1000, (i % 2 == 0) ? ST_DISCHARGE : ST_CHARGE);
        add_sample(16'd1000, bgal_pkg::STATUS_FULL);
        add_sample(16'd1000, ST_UNUSED);
        add_sample(16'd1050, ST_DISCHARGE);
        add_sample(16'd1100, ST_CHARGE);
        add_sample(16'd0, ST_DISCHARGE);
        add_sample(16'd0, ST_DISCHARGE);
        add_sample(16'(MAX_GOOD), bgal_pkg::STATUS_FULL);

        run_phase(7'd100, 0, 0);
        run_phase(7'd127, 50, 50);
        run_phase(7'd0, 20, 40);
        run_phase(7'($urandom_range(0, 127)), 40, 20);
        run_phase(7'd50, 0, 0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
        $display("covered %0d samples (%0d bad) over %0d initial_percent settings",
                 n_samples, n_bad, n_settings);
        $display("checked %0d percent reports, %0d errors", n_checked, n_errors);
        if (n_errors == 0)
            $display("battery_gauge_average_lookup: match");
        else
            $display("battery_gauge_average_lookup: mismatch");
        $finish;
    end

endmodule

FILE: battery_gauge_average_lookup.f
src/bgal_pkg.sv
src/bgal_seq.sv
src/bgal_datapath.sv
src/battery_gauge_average_lookup.sv
src/bgal_checker.sv
dv/tb_top.sv
